FILE: sv/zcd_pkg.sv
// Shared types, constants and register codes for the zebra crossing detector.
`default_nettype none

package zcd_pkg;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned FRAME_CNT_W = 6;
	localparam int unsigned PASS_W = 16;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [PIX_W-1:0] LAST_COUNTED_COL = 8'd158;
	localparam logic [PIX_W-1:0] COL_FIRST = 8'd0;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	// Signed bounds of the confirmation count, one bit wider than the counter.
	localparam logic signed [FRAME_CNT_W:0] CONFIRM_UP_LIMIT = 7'sd3;
	localparam logic signed [FRAME_CNT_W:0] CONFIRM_DOWN_LIMIT = -7'sd1;
	localparam logic [FRAME_CNT_W-1:0] ALARM_CNT_MAX = 6'd63;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_TOP_ROW = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_FLOOR_ROW = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TRANSITION_TARGET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_FRAMES = 3'd4;

	localparam logic [PIX_W-1:0] RST_PIXEL_THRESHOLD = 8'd128;
	localparam logic [PIX_W-1:0] RST_SCAN_TOP_ROW = 8'd110;
	localparam logic [PIX_W-1:0] RST_SCAN_FLOOR_ROW = 8'd80;
	localparam logic [COUNT_W-1:0] RST_TRANSITION_TARGET = 8'd10;
	localparam logic [FRAME_CNT_W-1:0] RST_HOLD_FRAMES = 6'd20;

	// Request codes on the input channel.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_END_FRAME = 1'b1;

	// Mode codes as shown on the result channel.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_CONFIRM = 2'd1;
	localparam logic [1:0] MODE_ALARM = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_CONFIRM = 3'b010,
		ST_ALARM   = 3'b100
	} conf_state_t;

	typedef struct packed {
		logic pix_en;
		logic eof_en;
	} step_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              buzzer;
		logic [PASS_W-1:0] pass_count;
		logic              seen;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/zcd_row_scan.sv
// Row scan: brightness threshold, per-row transition count and frame hit latch.
`default_nettype none

module zcd_row_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire zcd_pkg::step_t            step,
	input  wire logic [zcd_pkg::PIX_W-1:0] pixel,
	input  wire logic [zcd_pkg::PIX_W-1:0] row,
	input  wire logic [zcd_pkg::PIX_W-1:0] col,
	input  wire logic [zcd_pkg::PIX_W-1:0] pixel_threshold,
	input  wire logic [zcd_pkg::PIX_W-1:0] scan_top_row,
	input  wire logic [zcd_pkg::PIX_W-1:0] scan_floor_row,
	input  wire logic [zcd_pkg::COUNT_W-1:0] transition_target,
	output logic                           hit
);
	import zcd_pkg::*;

	logic               prev_bright_q;
	logic [COUNT_W-1:0] row_trans_q;
	logic               hit_q;

	logic               in_window;
	logic               bright;
	logic [COUNT_W-1:0] trans_next;

	assign in_window = (row <= scan_top_row) && (row > scan_floor_row)
		&& (col <= LAST_COUNTED_COL);
	assign bright = pixel > pixel_threshold;

	always_comb begin
		trans_next = row_trans_q;
		if (col == COL_FIRST) begin
			trans_next = '0;
		end else if (bright != prev_bright_q && row_trans_q != COUNT_MAX) begin
			trans_next = row_trans_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_bright_q <= 1'b0;
			row_trans_q   <= '0;
			hit_q         <= 1'b0;
		end else if (step.eof_en) begin
			prev_bright_q <= 1'b0;
			row_trans_q   <= '0;
			hit_q         <= 1'b0;
		end else if (step.pix_en && in_window) begin
			prev_bright_q <= bright;
			row_trans_q   <= trans_next;
			// check the row at its last counted column
			if (col == LAST_COUNTED_COL && trans_next > transition_target) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign hit = hit_q;

endmodule

`default_nettype wire

FILE: sv/zcd_confirm.sv
// Confirmation state machine run once per frame: idle, confirming, alarm.
`default_nettype none

module zcd_confirm (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire zcd_pkg::step_t                  step,
	input  wire logic                            hit,
	input  wire logic                            blocked,
	input  wire logic [zcd_pkg::FRAME_CNT_W-1:0] hold_frames,
	output zcd_pkg::status_t                     status_next
);
	import zcd_pkg::*;

	conf_state_t             state_q, state_d;
	logic [FRAME_CNT_W-1:0]  frame_cnt_q, frame_cnt_d;
	logic [PASS_W-1:0]       pass_q, pass_d;
	logic                    seen_q, seen_d;
	logic                    buzzer_q, buzzer_d;

	logic signed [FRAME_CNT_W:0] conf_cnt;
	logic [FRAME_CNT_W-1:0]      alarm_cnt;

	assign conf_cnt = $signed({frame_cnt_q[FRAME_CNT_W-1], frame_cnt_q})
		+ (hit ? 7'sd1 : -7'sd1);
	// alarm count is unsigned and saturates
	assign alarm_cnt = (frame_cnt_q < ALARM_CNT_MAX) ? frame_cnt_q + 1'b1 : frame_cnt_q;

	always_comb begin
		state_d     = state_q;
		frame_cnt_d = frame_cnt_q;
		pass_d      = pass_q;
		seen_d      = seen_q;
		buzzer_d    = buzzer_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!blocked && hit) begin
					seen_d  = 1'b1;
					state_d = ST_CONFIRM;
				end
			end
			ST_CONFIRM: begin
				if (hit) begin
					seen_d = 1'b1;
				end
				if (conf_cnt > CONFIRM_UP_LIMIT) begin
					frame_cnt_d = '0;
					state_d     = ST_ALARM;
					buzzer_d    = 1'b1;
				end else if (conf_cnt < CONFIRM_DOWN_LIMIT) begin
					frame_cnt_d = '0;
					state_d     = ST_IDLE;
				end else begin
					frame_cnt_d = conf_cnt[FRAME_CNT_W-1:0];
				end
			end
			ST_ALARM: begin
				if (hit) begin
					seen_d = 1'b1;
				end
				frame_cnt_d = alarm_cnt;
				if (!hit && alarm_cnt > hold_frames) begin
					buzzer_d    = 1'b0;
					frame_cnt_d = '0;
					pass_d      = pass_q + 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_cnt_q <= '0;
			pass_q      <= '0;
			seen_q      <= 1'b0;
			buzzer_q    <= 1'b0;
		end else if (step.eof_en) begin
			state_q     <= state_d;
			frame_cnt_q <= frame_cnt_d;
			pass_q      <= pass_d;
			seen_q      <= seen_d;
			buzzer_q    <= buzzer_d;
		end
	end

	always_comb begin
		unique case (state_d)
			ST_CONFIRM: status_next.mode = MODE_CONFIRM;
			ST_ALARM:   status_next.mode = MODE_ALARM;
			default:    status_next.mode = MODE_IDLE;
		endcase
		status_next.buzzer     = buzzer_d;
		status_next.pass_count = pass_d;
		status_next.seen       = seen_d;
	end

endmodule

`default_nettype wire

FILE: sv/zebra_crossing_detector_unit.sv
// Top level of the zebra crossing detector: request register, config, result register.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    cmd, pixel, row, col, other_feature_active
//   out      out_valid / out_ready  frame_hit, mode, buzzer, pass_count, seen
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while no end-of-frame request stalls; a request is registered, then
// handled from the request register. A pixel request yields no result; an end-of-frame
// request sets out_valid when it leaves the request register. The result register decouples
// the sides: pixels keep flowing while a result waits, and only an end-of-frame request stalls
// behind an untaken result. Reset clears the scan state, the confirmation machine and all valid
// flags; cfg_ready is always high.
`default_nettype none

module zebra_crossing_detector_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [zcd_pkg::PIX_W-1:0]           pixel,
	input  wire logic [zcd_pkg::PIX_W-1:0]           row,
	input  wire logic [zcd_pkg::PIX_W-1:0]           col,
	input  wire logic                                other_feature_active,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     frame_hit,
	output logic [1:0]                               mode,
	output logic                                     buzzer,
	output logic [zcd_pkg::PASS_W-1:0]               pass_count,
	output logic                                     seen,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [zcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [zcd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import zcd_pkg::*;

	// configuration
	logic [PIX_W-1:0]       pixel_threshold_q;
	logic [PIX_W-1:0]       scan_top_row_q;
	logic [PIX_W-1:0]       scan_floor_row_q;
	logic [COUNT_W-1:0]     transition_target_q;
	logic [FRAME_CNT_W-1:0] hold_frames_q;

	// request register
	logic             valid_s1;
	logic             cmd_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] row_s1;
	logic [PIX_W-1:0] col_s1;
	logic             ofa_s1;

	// result register
	logic    out_valid_q;
	logic    frame_hit_q;
	status_t status_q;

	logic    advance;
	step_t   step;
	logic    hit;
	status_t status_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_threshold_q   <= RST_PIXEL_THRESHOLD;
			scan_top_row_q      <= RST_SCAN_TOP_ROW;
			scan_floor_row_q    <= RST_SCAN_FLOOR_ROW;
			transition_target_q <= RST_TRANSITION_TARGET;
			hold_frames_q       <= RST_HOLD_FRAMES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PIXEL_THRESHOLD:   pixel_threshold_q   <= cfg_data;
				CFG_SCAN_TOP_ROW:      scan_top_row_q      <= cfg_data;
				CFG_SCAN_FLOOR_ROW:    scan_floor_row_q    <= cfg_data;
				CFG_TRANSITION_TARGET: transition_target_q <= cfg_data;
				CFG_HOLD_FRAMES:       hold_frames_q       <= cfg_data[FRAME_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// an end-of-frame request waits until the result register is free
	assign advance  = valid_s1 && (cmd_s1 == CMD_PIXEL || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign step.pix_en = advance && cmd_s1 == CMD_PIXEL;
	assign step.eof_en = advance && cmd_s1 == CMD_END_FRAME;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= cmd;
			pixel_s1 <= pixel;
			row_s1   <= row;
			col_s1   <= col;
			ofa_s1   <= other_feature_active;
		end
	end

	zcd_row_scan u_row_scan (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.pixel             (pixel_s1),
		.row               (row_s1),
		.col               (col_s1),
		.pixel_threshold   (pixel_threshold_q),
		.scan_top_row      (scan_top_row_q),
		.scan_floor_row    (scan_floor_row_q),
		.transition_target (transition_target_q),
		.hit               (hit)
	);

	zcd_confirm u_confirm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.hit         (hit),
		.blocked     (ofa_s1),
		.hold_frames (hold_frames_q),
		.status_next (status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.eof_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.eof_en) begin
			frame_hit_q <= hit;
			status_q    <= status_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_hit  = frame_hit_q;
	assign mode       = status_q.mode;
	assign buzzer     = status_q.buzzer;
	assign pass_count = status_q.pass_count;
	assign seen       = status_q.seen;

endmodule

`default_nettype wire

FILE: sv/zcd_checker.sv
// Port-level checks for the zebra crossing detector, bound to the top level.
`default_nettype none

module zcd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         frame_hit,
	input wire logic [1:0]                   mode,
	input wire logic                         buzzer,
	input wire logic [zcd_pkg::PASS_W-1:0]   pass_count,
	input wire logic                         seen
);
	import zcd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(pass_count)
			&& $stable(frame_hit))
		else $error("result changed while stalled");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mode == MODE_IDLE || mode == MODE_CONFIRM || mode == MODE_ALARM)
		else $error("undefined mode code on result");

	a_buzzer_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> buzzer == (mode == MODE_ALARM))
		else $error("buzzer does not follow alarm mode");

	a_seen_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode != MODE_IDLE |-> seen)
		else $error("active mode without seen flag");

endmodule

bind zebra_crossing_detector_unit zcd_checker u_zcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frame_hit  (frame_hit),
	.mode       (mode),
	.buzzer     (buzzer),
	.pass_count (pass_count),
	.seen       (seen)
);

`default_nettype wire
